>>> design/cdu_pkg.sv
// ============================================================================
// cdu_pkg: shared types and tables of the calendar date unit
// Item structs, the state encoding, the shared adder word and the month tables.
// ============================================================================
`default_nettype none

package cdu_pkg;

	// Opcodes of an input item.
	localparam logic [1:0] OP_DATE_TO_DOY = 2'd0;
	localparam logic [1:0] OP_DOY_TO_DATE = 2'd1;
	localparam logic [1:0] OP_WEEKDAY     = 2'd2;

	// Status codes of a result item.
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_INVALID = 1'b1;

	// Width of the shared add/subtract unit; holds a 14-bit year with headroom.
	localparam int ALU_W = 15;
	typedef logic [ALU_W-1:0] word_t;

	// Reciprocals for the divisions by constants: floor(n / 100) is
	// (n * RECIP100) >> RECIP100_SHIFT for every 14-bit n, and floor(n / 7)
	// is (n * RECIP7) >> RECIP7_SHIFT for every n below 682.
	localparam logic [12:0] RECIP100       = 13'd5243;
	localparam int          RECIP100_SHIFT = 19;
	localparam logic [8:0]  RECIP7         = 9'd293;
	localparam int          RECIP7_SHIFT   = 11;

	// Offset that keeps the weekday sum positive; a multiple of seven.
	localparam word_t WEEK_BIAS = word_t'(336);

	typedef struct packed {
		logic [1:0]  opcode;
		logic [13:0] year;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [8:0]  day_of_year_in;
	} cdu_req_t;

	typedef struct packed {
		logic       status;
		logic [8:0] day_of_year_out;
		logic [3:0] month_out;
		logic [4:0] day_out;
		logic [2:0] weekday;
		logic       is_weekend;
		logic       leap_year;
	} cdu_rsp_t;

	typedef struct packed {
		word_t a;
		word_t b;
		logic  sub;
	} alu_req_t;

	typedef struct packed {
		word_t res;
		logic  carry;
		logic  zero;
	} alu_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_MADD,
		ST_MSUB,
		ST_MOD,
		ST_DONE
	} cdu_state_t;

	// Days in month m (1..12) of a common or leap year.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2:                     len = 5'd28 + {4'b0, leap};
			4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
			default:                  len = 5'd31;
		endcase
		return len;
	endfunction

	// Month term floor(26 * (mm + 1) / 10) of Zeller's congruence, where
	// January and February count as months 13 and 14 of the prior year.
	function automatic logic [5:0] zeller_month(input logic [3:0] m);
		logic [5:0] t;
		case (m)
			4'd1:    t = 6'd36;
			4'd2:    t = 6'd39;
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

>>> design/calendar_date_unit.sv
// ============================================================================
// calendar_date_unit: Gregorian day-of-year, date and weekday unit
// Top level: input handshake, sequencer, shared adder and result register.
// ============================================================================
// Use of the block:
// An item enters on the req channel (req_valid/req_ready) with an opcode, a
// year, a month, a day and an ordinal day. Opcode 0 turns a date into its day
// of the year, opcode 1 turns a day of the year into month and day, and
// opcode 2 gives the weekday (0 is Sunday) and a weekend flag. Each item gives
// exactly one result item on the rsp channel (rsp_valid/rsp_ready); every
// result carries the leap-year flag, and invalid input gives status 1 with
// the other result fields zero.
// All sums run through one add/subtract unit. The year is split by 100 with a
// reciprocal multiply at acceptance and one subtract, then opcode 0 adds one
// month length per cycle, opcode 1 subtracts one per cycle, and opcode 2 takes
// the Zeller sum mod 7 with a reciprocal multiply and one subtract. Opcode 0
// walks the months up to the input month and opcode 1 up to the result month;
// invalid items skip the walk. req_ready is high only while the sequencer is
// idle, so no new item is taken until the last result has left the sequencer.
// The finished result sits in an output register, so one more item is accepted
// and worked while the receiver stalls; after that req_ready stays low.
// Reset empties the sequencer and the output register; nothing else is kept.
// ============================================================================
`default_nettype none

module calendar_date_unit (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  cdu_pkg::cdu_req_t  req,
	output logic               rsp_valid,
	input  wire                rsp_ready,
	output cdu_pkg::cdu_rsp_t  rsp
);

	cdu_pkg::alu_req_t alu_req;
	cdu_pkg::alu_rsp_t alu_rsp;
	cdu_pkg::cdu_rsp_t seq_rsp;
	cdu_pkg::cdu_rsp_t rsp_q;
	logic              rsp_valid_q;
	logic              seq_idle;
	logic              seq_done;
	logic              start;
	logic              take;

	assign req_ready = seq_idle;
	assign start     = req_valid && seq_idle;

	// A finished result moves into the output register once it is free.
	assign take = seq_done && (!rsp_valid_q || rsp_ready);

	cdu_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.idle    (seq_idle),
		.done    (seq_done),
		.take    (take),
		.rsp     (seq_rsp),
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

	cdu_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= seq_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> design/cdu_alu.sv
// ============================================================================
// cdu_alu: shared add/subtract unit
// One adder that either adds or subtracts, with carry (no borrow) and zero.
// ============================================================================
`default_nettype none

module cdu_alu (
	input  cdu_pkg::alu_req_t req,
	output cdu_pkg::alu_rsp_t rsp
);

	logic [cdu_pkg::ALU_W:0] sum;
	cdu_pkg::word_t          b_op;

	// Subtraction is a + ~b + 1; carry set means a >= b.
	assign b_op = req.sub ? ~req.b : req.b;
	assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{cdu_pkg::ALU_W{1'b0}}, req.sub};

	assign rsp.res   = sum[cdu_pkg::ALU_W-1:0];
	assign rsp.carry = sum[cdu_pkg::ALU_W];
	assign rsp.zero  = (sum[cdu_pkg::ALU_W-1:0] == '0);

endmodule

`default_nettype wire

>>> design/cdu_seq.sv
// ============================================================================
// cdu_seq: sequencer and working registers of the calendar date unit
// Splits the year by 100, then walks months or reduces the weekday sum mod 7.
// ============================================================================
`default_nettype none

module cdu_seq (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  cdu_pkg::cdu_req_t  req,
	output logic               idle,
	output logic               done,
	input  wire                take,
	output cdu_pkg::cdu_rsp_t  rsp,
	output cdu_pkg::alu_req_t  alu_req,
	input  cdu_pkg::alu_rsp_t  alu_rsp
);

	cdu_pkg::cdu_state_t state_q, state_d;

	logic [1:0]     op_q;
	logic [13:0]    year_q;
	logic [3:0]     mon_q;
	logic [4:0]     day_q;
	logic [8:0]     yday_q;
	cdu_pkg::word_t acc_q;
	logic [7:0]     quo_q;
	logic           phase_q;
	logic [3:0]     mcnt_q;
	logic           leap_q;
	cdu_pkg::cdu_rsp_t rsp_q;

	logic [26:0]    prod100;
	logic [18:0]    prod7;
	cdu_pkg::word_t hundreds;
	cdu_pkg::word_t sevens;
	logic [6:0]     rem100;
	logic           leap_c;
	logic           early;
	logic           wrap;
	logic [6:0]     zk;
	logic [7:0]     zj;
	cdu_pkg::word_t wsum;
	logic [4:0]     mlen;
	logic           mon_ok;
	logic           date_ok;
	logic           doy_ok;

	// Quotients by reciprocal multiplication; the shared unit then subtracts
	// the multiple of the divisor to leave the remainder.
	assign prod100  = 27'(req.year) * 27'(cdu_pkg::RECIP100);
	assign prod7    = 19'(acc_q[9:0]) * 19'(cdu_pkg::RECIP7);
	assign hundreds = cdu_pkg::word_t'({quo_q, 6'd0}) + cdu_pkg::word_t'({quo_q, 5'd0})
		+ cdu_pkg::word_t'({quo_q, 2'd0});
	assign sevens   = cdu_pkg::word_t'({quo_q, 3'd0}) - cdu_pkg::word_t'(quo_q);

	// After the split, acc holds year % 100 and quo holds year / 100.
	assign rem100 = acc_q[6:0];
	assign leap_c = (year_q[1:0] == 2'd0) && ((rem100 != 7'd0) || (quo_q[1:0] == 2'd0));

	// Zeller works on year + 400, one year earlier for January and February.
	assign early = (mon_q <= 4'd2);
	assign wrap  = early && (rem100 == 7'd0);
	assign zk    = early ? (wrap ? 7'd99 : rem100 - 7'd1) : rem100;
	assign zj    = quo_q + 8'd4 - {7'b0, wrap};
	assign wsum  = cdu_pkg::WEEK_BIAS
		+ cdu_pkg::word_t'(zk) + cdu_pkg::word_t'(zk[6:2]) + cdu_pkg::word_t'(zj[7:2])
		+ cdu_pkg::word_t'(cdu_pkg::zeller_month(mon_q)) + cdu_pkg::word_t'(day_q)
		- cdu_pkg::word_t'(1) - cdu_pkg::word_t'({zj, 1'b0});

	assign mon_ok  = (mon_q inside {[4'd1:4'd12]});
	assign date_ok = mon_ok && (day_q != 5'd0) && (day_q <= cdu_pkg::month_days(mon_q, leap_c));
	assign doy_ok  = (yday_q != 9'd0) && (yday_q <= 9'd365 + {8'b0, leap_c});
	assign mlen    = cdu_pkg::month_days(mcnt_q, leap_q);

	assign idle = (state_q == cdu_pkg::ST_IDLE);
	assign done = (state_q == cdu_pkg::ST_DONE);
	assign rsp  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		alu_req.a   = acc_q;
		alu_req.b   = hundreds;
		alu_req.sub = 1'b1;
		case (state_q)
			cdu_pkg::ST_IDLE: begin
				if (start) begin
					state_d = cdu_pkg::ST_DIV;
				end
			end
			cdu_pkg::ST_DIV: begin
				state_d = cdu_pkg::ST_SETUP;
			end
			cdu_pkg::ST_SETUP: begin
				case (op_q)
					cdu_pkg::OP_DATE_TO_DOY: state_d = date_ok ? cdu_pkg::ST_MADD : cdu_pkg::ST_DONE;
					cdu_pkg::OP_DOY_TO_DATE: state_d = doy_ok ? cdu_pkg::ST_MSUB : cdu_pkg::ST_DONE;
					cdu_pkg::OP_WEEKDAY:     state_d = mon_ok ? cdu_pkg::ST_MOD : cdu_pkg::ST_DONE;
					default:                 state_d = cdu_pkg::ST_DONE;
				endcase
			end
			cdu_pkg::ST_MADD: begin
				alu_req.b   = cdu_pkg::word_t'(mlen);
				alu_req.sub = 1'b0;
				if (mcnt_q >= mon_q) begin
					state_d = cdu_pkg::ST_DONE;
				end
			end
			cdu_pkg::ST_MSUB: begin
				alu_req.b = cdu_pkg::word_t'(mlen);
				if (!((mcnt_q < 4'd12) && alu_rsp.carry && !alu_rsp.zero)) begin
					state_d = cdu_pkg::ST_DONE;
				end
			end
			cdu_pkg::ST_MOD: begin
				alu_req.b = sevens;
				if (phase_q) begin
					state_d = cdu_pkg::ST_DONE;
				end
			end
			cdu_pkg::ST_DONE: begin
				if (take) begin
					state_d = cdu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cdu_pkg::ST_IDLE;
			end
		endcase
	end

	// Working registers carry data only; the state register above gates them.
	always_ff @(posedge clk) begin
		case (state_q)
			cdu_pkg::ST_IDLE: begin
				if (start) begin
					op_q   <= req.opcode;
					year_q <= req.year;
					mon_q  <= req.month_in;
					day_q  <= req.day_in;
					yday_q <= req.day_of_year_in;
					acc_q  <= cdu_pkg::word_t'(req.year);
					quo_q  <= prod100[cdu_pkg::RECIP100_SHIFT +: 8];
				end
			end
			cdu_pkg::ST_DIV: begin
				acc_q <= alu_rsp.res;
			end
			cdu_pkg::ST_SETUP: begin
				leap_q                <= leap_c;
				mcnt_q                <= 4'd1;
				phase_q               <= 1'b0;
				rsp_q.status          <= cdu_pkg::STATUS_INVALID;
				rsp_q.day_of_year_out <= 9'd0;
				rsp_q.month_out       <= 4'd0;
				rsp_q.day_out         <= 5'd0;
				rsp_q.weekday         <= 3'd0;
				rsp_q.is_weekend      <= 1'b0;
				rsp_q.leap_year       <= leap_c;
				case (op_q)
					cdu_pkg::OP_DATE_TO_DOY: acc_q <= cdu_pkg::word_t'(day_q);
					cdu_pkg::OP_DOY_TO_DATE: acc_q <= cdu_pkg::word_t'(yday_q);
					default:                 acc_q <= wsum;
				endcase
			end
			cdu_pkg::ST_MADD: begin
				if (mcnt_q < mon_q) begin
					acc_q  <= alu_rsp.res;
					mcnt_q <= mcnt_q + 4'd1;
				end else begin
					rsp_q.status          <= cdu_pkg::STATUS_OK;
					rsp_q.day_of_year_out <= acc_q[8:0];
				end
			end
			cdu_pkg::ST_MSUB: begin
				if ((mcnt_q < 4'd12) && alu_rsp.carry && !alu_rsp.zero) begin
					acc_q  <= alu_rsp.res;
					mcnt_q <= mcnt_q + 4'd1;
				end else begin
					rsp_q.status    <= cdu_pkg::STATUS_OK;
					rsp_q.month_out <= mcnt_q;
					rsp_q.day_out   <= acc_q[4:0];
				end
			end
			cdu_pkg::ST_MOD: begin
				// First the quotient by seven, then the remainder.
				if (!phase_q) begin
					quo_q   <= prod7[cdu_pkg::RECIP7_SHIFT +: 8];
					phase_q <= 1'b1;
				end else begin
					rsp_q.status     <= cdu_pkg::STATUS_OK;
					rsp_q.weekday    <= alu_rsp.res[2:0];
					rsp_q.is_weekend <= (alu_rsp.res[2:0] == 3'd0) || (alu_rsp.res[2:0] == 3'd6);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench of the calendar date unit
// Sends date, day-of-year and weekday items over the req channel, predicts
// each result item from its own model of the Gregorian calendar, and checks
// every result item field by field in arrival order. Both channels idle at
// random, and one long receiver stall makes the block hold off its input.
// ============================================================================

module tb_top;

	// The package names only the three real operations; the fourth opcode
	// is unused and must come back as invalid.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Number of random items after the directed tests.
	localparam int RANDOM_ITEMS = 610;

	// Receiver hold-off of the input stall test, in cycles.
	localparam int LONG_HOLD = 400;

	// Cycles to wait after the last result, so that nothing the block could
	// still send is missed.
	localparam int SETTLE_CYCLES = 60;

	// Hard stop. The slowest correct run is about 650 items, plus the long
	// hold-off and reset. This is several times that.
	localparam int CYCLE_LIMIT = 200000;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_ready;
	cdu_pkg::cdu_req_t req;
	logic              rsp_valid;
	logic              rsp_ready;
	cdu_pkg::cdu_rsp_t rsp;

	// Result items predicted for accepted input items, oldest first.
	cdu_pkg::cdu_rsp_t pending_results[$];

	int mismatch_count = 0;
	int cycle_count = 0;

	// When low, neither side inserts random gaps.
	bit idling_on = 1'b1;

	// Set by a test to ask the receiver for one long hold-off.
	int rsp_hold_cycles = 0;

	calendar_date_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------------

	// Gregorian rule: every fourth year, except centuries that are not a
	// multiple of 400. Year zero counts as a leap year.
	function automatic logic is_leap_year(input logic [13:0] y);
		if (y % 100 == 0)
			return (y % 400 == 0);
		return (y % 4 == 0);
	endfunction

	// Length of month m (1..12).
	function automatic int days_in_month(input int m, input logic leap);
		case (m)
			2:           return 28 + leap;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// Expected result item for one input item. Invalid input leaves all
	// result fields zero except the status and the leap flag.
	function automatic cdu_pkg::cdu_rsp_t calendar_result(input cdu_pkg::cdu_req_t item);
		cdu_pkg::cdu_rsp_t r;
		logic     leap;
		int       total;
		int       rest;
		int       mon;
		int       y;
		int       mm;
		int       yy;
		int       cent;
		int       w;
		r = '0;
		leap = is_leap_year(item.year);
		r.leap_year = leap;
		r.status = cdu_pkg::STATUS_INVALID;
		case (item.opcode)
			cdu_pkg::OP_DATE_TO_DOY: begin
				if (item.month_in >= 1 && item.month_in <= 12 && item.day_in >= 1 &&
						item.day_in <= days_in_month(item.month_in, leap)) begin
					total = item.day_in;
					for (mon = 1; mon < item.month_in; mon++)
						total += days_in_month(mon, leap);
					r.day_of_year_out = 9'(total);
					r.status = cdu_pkg::STATUS_OK;
				end
			end
			cdu_pkg::OP_DOY_TO_DATE: begin
				if (item.day_of_year_in >= 1 && item.day_of_year_in <= 365 + leap) begin
					rest = item.day_of_year_in;
					mon = 1;
					while (mon < 12 && rest > days_in_month(mon, leap)) begin
						rest -= days_in_month(mon, leap);
						mon++;
					end
					r.month_out = 4'(mon);
					r.day_out = 5'(rest);
					r.status = cdu_pkg::STATUS_OK;
				end
			end
			cdu_pkg::OP_WEEKDAY: begin
				// Only the month is checked; the day is counted as given,
				// even past the end of the month.
				if (item.month_in >= 1 && item.month_in <= 12) begin
					// One 400-year cycle added keeps the year positive, so
					// January and February of year zero still have a prior year.
					y = int'(item.year) + 400;
					mm = item.month_in;
					if (mm <= 2) begin
						y -= 1;
						mm += 12;
					end
					yy = y % 100;
					cent = y / 100;
					w = yy + yy / 4 + cent / 4 - 2 * cent + (26 * (mm + 1)) / 10 +
						int'(item.day_in) - 1;
					w %= 7;
					if (w < 0)
						w += 7;
					r.weekday = 3'(w);
					r.is_weekend = (w == 0 || w == 6);
					r.status = cdu_pkg::STATUS_OK;
				end
			end
			default: begin
				// The unused opcode stays invalid.
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic cdu_pkg::cdu_req_t make_item(input logic [1:0] op, input int year,
			input int month, input int day, input int doy);
		cdu_pkg::cdu_req_t item;
		item.opcode = op;
		item.year = 14'(year);
		item.month_in = 4'(month);
		item.day_in = 5'(day);
		item.day_of_year_in = 9'(doy);
		return item;
	endfunction

	// Mostly well-formed items with random content; the rest is noise that
	// covers every value the fields can hold.
	function automatic cdu_pkg::cdu_req_t random_item();
		cdu_pkg::cdu_req_t item;
		logic     leap;
		int       pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			item.opcode = OP_UNUSED;
		else if (pick <= 6)
			item.opcode = cdu_pkg::OP_DATE_TO_DOY;
		else if (pick <= 12)
			item.opcode = cdu_pkg::OP_DOY_TO_DATE;
		else
			item.opcode = cdu_pkg::OP_WEEKDAY;

		// Century years and the full 14-bit range get extra weight.
		pick = $urandom_range(0, 9);
		if (pick == 0)
			item.year = 14'($urandom_range(0, 16383));
		else if (pick == 1)
			item.year = 14'(100 * $urandom_range(0, 163));
		else if (pick == 2)
			item.year = 14'(400 * $urandom_range(0, 40));
		else
			item.year = 14'($urandom_range(1, 9999));
		leap = is_leap_year(item.year);

		if ($urandom_range(0, 7) == 0)
			item.month_in = 4'($urandom_range(0, 15));
		else
			item.month_in = 4'($urandom_range(1, 12));

		pick = $urandom_range(0, 9);
		if (item.month_in < 1 || item.month_in > 12 || pick == 0)
			item.day_in = 5'($urandom_range(0, 31));
		else if (pick == 1)
			item.day_in = 5'(days_in_month(item.month_in, leap));
		else
			item.day_in = 5'($urandom_range(1, days_in_month(item.month_in, leap)));

		pick = $urandom_range(0, 9);
		if (pick == 0)
			item.day_of_year_in = 9'($urandom_range(0, 511));
		else if (pick == 1)
			item.day_of_year_in = 9'(365 + leap);
		else if (pick == 2)
			item.day_of_year_in = 9'($urandom_range(58, 61));
		else
			item.day_of_year_in = 9'($urandom_range(1, 365 + leap));
		return item;
	endfunction

	// Offer one item after a random gap and wait until the block takes it.
	// Valid stays high across back-to-back items, so it is never lowered and
	// raised again in the same step.
	task automatic send_item(input cdu_pkg::cdu_req_t item);
		int gap;
		gap = idling_on ? $urandom_range(0, 4) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_results.push_back(calendar_result(item));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Month and day checks, month-length sums, and the 29 February rule.
	task automatic test_date_to_day_of_year();
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 2023, 1, 1, 0));
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 2023, 12, 31, 0));
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 2024, 12, 31, 0));
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 2024, 2, 29, 0));
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 2023, 2, 29, 0));
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 1900, 2, 29, 0));
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 2000, 2, 29, 0));
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 2023, 0, 1, 0));
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 2023, 4, 31, 0));
		send_item(make_item(cdu_pkg::OP_DATE_TO_DOY, 2023, 3, 0, 0));
	endtask

	// Ordinal day bounds, day 60 in common and leap years, and the year end.
	task automatic test_day_of_year_to_date();
		send_item(make_item(cdu_pkg::OP_DOY_TO_DATE, 2023, 0, 0, 0));
		send_item(make_item(cdu_pkg::OP_DOY_TO_DATE, 2023, 0, 0, 1));
		send_item(make_item(cdu_pkg::OP_DOY_TO_DATE, 2023, 0, 0, 60));
		send_item(make_item(cdu_pkg::OP_DOY_TO_DATE, 2024, 0, 0, 60));
		send_item(make_item(cdu_pkg::OP_DOY_TO_DATE, 2023, 0, 0, 365));
		send_item(make_item(cdu_pkg::OP_DOY_TO_DATE, 2023, 0, 0, 366));
		send_item(make_item(cdu_pkg::OP_DOY_TO_DATE, 2024, 0, 0, 366));
		send_item(make_item(cdu_pkg::OP_DOY_TO_DATE, 2024, 15, 31, 511));
	endtask

	// Weekdays of year zero, of the largest year, and of days past the end
	// of a month, plus an invalid month and the unused opcode.
	task automatic test_weekday();
		send_item(make_item(cdu_pkg::OP_WEEKDAY, 2024, 1, 1, 0));
		send_item(make_item(cdu_pkg::OP_WEEKDAY, 0, 1, 1, 0));
		send_item(make_item(cdu_pkg::OP_WEEKDAY, 0, 2, 29, 0));
		send_item(make_item(cdu_pkg::OP_WEEKDAY, 16383, 12, 31, 511));
		send_item(make_item(cdu_pkg::OP_WEEKDAY, 2023, 2, 31, 0));
		send_item(make_item(cdu_pkg::OP_WEEKDAY, 2023, 2, 0, 0));
		send_item(make_item(cdu_pkg::OP_WEEKDAY, 9999, 15, 31, 0));
		send_item(make_item(OP_UNUSED, 16383, 15, 31, 511));
	endtask

	// The receiver holds off for a long stretch while items keep coming
	// back to back, so the output register fills and req_ready stays low.
	task automatic test_input_stall();
		int n;
		idling_on = 1'b0;
		rsp_hold_cycles = LONG_HOLD;
		for (n = 0; n < 10; n++)
			send_item(random_item());
		idling_on = 1'b1;
	endtask

	// Random items in blocks of 100; every third block runs without gaps.
	task automatic test_random_items();
		int n;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				idling_on = ((n / 100) % 3 != 1);
			send_item(random_item());
		end
		idling_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_date_to_day_of_year();
		test_day_of_year_to_date();
		test_weekday();
		test_input_stall();
		test_random_items();

		@(negedge clk);
		req_valid <= 1'b0;

		// Wait for every outstanding result; the cycle limit catches a hang.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: draws a stall before each result item, or takes a long
	// hold-off when a test asks for one. Ready is raised once per item and
	// stays high until the item is taken.
	initial begin : rsp_side
		int stall;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				stall = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else if (idling_on) begin
				stall = $urandom_range(0, 4);
			end else begin
				stall = 0;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Each result item taken is compared with the oldest prediction.
	always @(posedge clk) begin : result_check
		cdu_pkg::cdu_rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item arrived with no prediction pending");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("day_of_year_out", want.day_of_year_out, rsp.day_of_year_out);
				check_field("month_out", want.month_out, rsp.month_out);
				check_field("day_out", want.day_out, rsp.day_out);
				check_field("weekday", want.weekday, rsp.weekday);
				check_field("is_weekend", want.is_weekend, rsp.is_weekend);
				check_field("leap_year", want.leap_year, rsp.leap_year);
			end
		end
	end

	// A run that goes on far past its slowest correct length has hung.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
